// File: hw/rtl/lru_key_value_cache_unit_assert.svh
`ifndef LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define LKVC_ASSERT_IMPL(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lkvc assertion failed");
`define LKVC_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lkvc assertion failed");
`else
`define LKVC_ASSERT_IMPL(label, ck, rn, ante, cons)
`define LKVC_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

// File: hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef struct packed {
    logic               mode;
    logic signed [31:0] key;
    logic signed [31:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } out_word_t;

endpackage

// File: hw/rtl/lru_key_value_cache_unit.sv
// LRU key/value cache, fully associative, MAX_ENTRIES slots.
// Input channel (in_valid/in_stall/in_word): one word per lookup (mode 0)
// or write (mode 1). A word is taken when in_valid is high and in_stall low.
// Output channel (out_valid/out_stall/out_word): exactly one result word per
// input word, in order: hit flag, read value, eviction flag and evicted key.
// Config channel (cfg_valid/cfg_ready/cfg_data): capacity_in_use; the user must
// write it only while the block is idle, which the block does not enforce; cfg_ready is always high.
// Timing: a word is accepted in the idle state, the sequencer then steps a
// single key/rank compare unit over all MAX_ENTRIES slots, one per cycle,
// and commits in the update state, which waits while the output register
// is full and stalled. A new word is taken only once the last is committed.
// in_stall is high from accept until the result is loaded.
// If the receiver stalls, the result holds in the output register and the
// next word is still accepted and scanned; its update waits until the
// output register frees.
// Reset (rst_n low, synchronous) clears all valid bits, ranks, the entry
// count and sets capacity to 16. Keys and values are not cleared.
module lru_key_value_cache_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lkvc_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lkvc_pkg::out_word_t         out_word,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  localparam int N  = lkvc_pkg::MAX_ENTRIES;
  localparam int IW = lkvc_pkg::IDX_W;
  localparam int CW = lkvc_pkg::CNT_W;
  localparam int MW = lkvc_pkg::CMP_W;

  state_t state_r, state_nxt;

  logic [31:0]          key_mem   [N];
  logic [31:0]          val_mem   [N];
  logic [IW-1:0]        rank_r    [N];
  logic [N-1:0]         valid_r;
  logic [CW-1:0]        count_r;
  logic [lkvc_pkg::CAP_W-1:0] cap_r;

  lkvc_pkg::in_word_t   item_r;
  logic [IW-1:0]        idx_r;
  logic                 found_r;
  logic [IW-1:0]        slot_r;
  logic [IW-1:0]        old_rank_r;
  logic [31:0]          hit_val_r;
  logic                 have_r;
  logic [IW-1:0]        best_r;
  logic [IW-1:0]        lru_slot_r;
  logic [31:0]          lru_key_r;
  logic                 free_found_r;
  logic [IW-1:0]        free_slot_r;

  logic                 out_valid_r;
  lkvc_pkg::out_word_t  out_word_r;

  logic                 accept;
  logic                 last_idx;
  logic                 out_free;
  logic                 commit;
  logic                 cur_valid;
  logic                 key_match;
  logic                 lru_take;
  logic [MW-1:0]        eff_cap;
  logic                 do_evict;
  logic                 do_ins;
  logic [IW-1:0]        ins_slot;

  assign accept    = (state_r == ST_IDLE) && in_valid;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign last_idx  = (idx_r == IW'(N - 1));
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_UPD) && out_free;

  assign cur_valid = valid_r[idx_r];
  assign key_match = cur_valid && (key_mem[idx_r] == item_r.key);
  assign lru_take  = cur_valid && (!have_r || (rank_r[idx_r] >= best_r));

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = MW'(1);
    end else if (MW'(cap_r) > MW'(N)) begin
      eff_cap = MW'(N);
    end else begin
      eff_cap = MW'(cap_r);
    end
  end

  assign do_evict = !found_r && item_r.mode && (MW'(count_r) >= eff_cap) && have_r;
  assign do_ins   = !found_r && item_r.mode && (do_evict || free_found_r);

  always_comb begin
    if (do_evict && !(free_found_r && (free_slot_r < lru_slot_r))) begin
      ins_slot = lru_slot_r;
    end else begin
      ins_slot = free_slot_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN: if (last_idx) state_nxt = ST_UPD;
      ST_UPD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // scan: one slot per cycle through the shared compare unit
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r       <= in_word;
      idx_r        <= '0;
      found_r      <= 1'b0;
      have_r       <= 1'b0;
      free_found_r <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      idx_r <= idx_r + IW'(1);
      if (key_match && !found_r) begin
        found_r    <= 1'b1;
        slot_r     <= idx_r;
        old_rank_r <= rank_r[idx_r];
        hit_val_r  <= val_mem[idx_r];
      end
      if (lru_take) begin
        have_r     <= 1'b1;
        best_r     <= rank_r[idx_r];
        lru_slot_r <= idx_r;
        lru_key_r  <= key_mem[idx_r];
      end
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_slot_r  <= idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (found_r && item_r.mode) begin
        val_mem[slot_r] <= item_r.write_value;
      end else if (do_ins) begin
        key_mem[ins_slot] <= item_r.key;
        val_mem[ins_slot] <= item_r.write_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      for (int i = 0; i < N; i++) begin
        rank_r[i] <= '0;
      end
    end else if (commit) begin
      if (found_r) begin
        for (int i = 0; i < N; i++) begin
          if (valid_r[i] && (IW'(i) != slot_r) && (rank_r[i] < old_rank_r)) begin
            rank_r[i] <= rank_r[i] + IW'(1);
          end
        end
        rank_r[slot_r] <= '0;
      end else if (do_ins) begin
        for (int i = 0; i < N; i++) begin
          if (valid_r[i] && (IW'(i) != ins_slot) &&
              !(do_evict && (IW'(i) == lru_slot_r))) begin
            rank_r[i] <= rank_r[i] + IW'(1);
          end
        end
        rank_r[ins_slot]  <= '0;
        valid_r[ins_slot] <= 1'b1;
        if (!do_evict) begin
          count_r <= count_r + CW'(1);
        end
      end
      // an evict whose slot is not reused
      if (do_evict && (ins_slot != lru_slot_r)) begin
        valid_r[lru_slot_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_word_r.hit         <= found_r;
      out_word_r.read_value  <= (found_r && !item_r.mode) ? hit_val_r : '0;
      out_word_r.evicted     <= do_evict;
      out_word_r.evicted_key <= do_evict ? lru_key_r : '0;
    end
  end

`include "lru_key_value_cache_unit_assert.svh"

  `LKVC_ASSERT_IMPL(a_count_matches_valid, clk, rst_n, 1'b1, $countones(valid_r) == int'(count_r))
  `LKVC_ASSERT_IMPL(a_no_hit_and_evict, clk, rst_n, out_valid, !(out_word.hit && out_word.evicted))
  `LKVC_ASSERT_IMPL(a_miss_reads_zero, clk, rst_n, out_valid && !out_word.hit, out_word.read_value == '0)
  `LKVC_ASSERT_NEXT(a_commit_loads_out, clk, rst_n, commit, out_valid && (state_r == ST_IDLE))

endmodule

// File: test/lru_result_checker.sv
module lru_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  lkvc_pkg::in_word_t         in_word,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  lkvc_pkg::out_word_t        out_word,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data,
  output int                         pending,
  output int                         fail_count
);
  import lkvc_pkg::*;

  logic signed [31:0] slot_key   [MAX_ENTRIES];
  logic signed [31:0] slot_value [MAX_ENTRIES];
  logic               slot_valid [MAX_ENTRIES];
  logic [IDX_W-1:0]   slot_rank  [MAX_ENTRIES];
  logic [CNT_W-1:0]   used_count;
  logic [CAP_W-1:0]   capacity;
  out_word_t          expected_results[$];

  initial begin
    pending    = 0;
    fail_count = 0;
  end

  // rank 0 is most recent; entries more recent than old_rank age by one
  function automatic void move_to_front(int s, int old_rank);
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (slot_valid[i] && i != s && int'(slot_rank[i]) < old_rank) begin
        slot_rank[i] = slot_rank[i] + 1'b1;
      end
    end
    slot_rank[s] = '0;
  endfunction

  function automatic out_word_t lru_access(in_word_t w);
    out_word_t r;
    int        hit_slot;
    int        free_slot;
    int        victim;
    int        limit;
    r         = '0;
    hit_slot  = -1;
    free_slot = -1;
    victim    = -1;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (hit_slot < 0 && slot_valid[i] && slot_key[i] == w.key) begin
        hit_slot = i;
      end
    end
    if (hit_slot >= 0) begin
      r.hit = 1'b1;
      if (w.mode) begin
        slot_value[hit_slot] = w.write_value;
      end else begin
        r.read_value = slot_value[hit_slot];
      end
      move_to_front(hit_slot, int'(slot_rank[hit_slot]));
    end else if (w.mode) begin
      limit = (capacity == 0) ? 1 : (int'(capacity) > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity);
      if (int'(used_count) >= limit) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (slot_valid[i] && (victim < 0 || slot_rank[i] >= slot_rank[victim])) begin
            victim = i;
          end
        end
        if (victim >= 0) begin
          r.evicted          = 1'b1;
          r.evicted_key      = slot_key[victim];
          slot_valid[victim] = 1'b0;
          used_count         = used_count - 1'b1;
        end
      end
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (free_slot < 0 && !slot_valid[i]) begin
          free_slot = i;
        end
      end
      if (free_slot >= 0) begin
        slot_key[free_slot]   = w.key;
        slot_value[free_slot] = w.write_value;
        slot_valid[free_slot] = 1'b1;
        used_count            = used_count + 1'b1;
        move_to_front(free_slot, MAX_ENTRIES);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = '0;
      end
      used_count = '0;
      capacity   = CAP_RESET;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing outstanding", out_word));
        end else begin
          exp_w = expected_results.pop_front();
          if (out_word.hit !== exp_w.hit) begin
            report_mismatch($sformatf("hit %b, want %b", out_word.hit, exp_w.hit));
          end
          if (out_word.read_value !== exp_w.read_value) begin
            report_mismatch($sformatf("read_value %h, want %h",
                                      out_word.read_value, exp_w.read_value));
          end
          if (out_word.evicted !== exp_w.evicted) begin
            report_mismatch($sformatf("evicted %b, want %b", out_word.evicted, exp_w.evicted));
          end
          if (out_word.evicted_key !== exp_w.evicted_key) begin
            report_mismatch($sformatf("evicted_key %h, want %h",
                                      out_word.evicted_key, exp_w.evicted_key));
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(lru_access(in_word));
      end
    end
    pending = expected_results.size();
  end

endmodule

// File: test/lru_key_value_cache_unit_tb.sv
module lru_key_value_cache_unit_tb;
  import lkvc_pkg::*;

  localparam logic        MODE_LOOKUP = 1'b0;
  localparam logic        MODE_WRITE  = 1'b1;
  localparam logic [31:0] KEY_MIN     = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX     = 32'h7fff_ffff;
  localparam logic [31:0] KEY_ZERO    = 32'h0000_0000;
  localparam logic [31:0] KEY_ONES    = 32'hffff_ffff;
  localparam int          POOL_SIZE   = 24;
  localparam int          HOLD_CYCLES = 300;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_word_t         in_word;
  logic             out_valid;
  logic             out_stall;
  out_word_t        out_word;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  int          pending;
  int          fail_count;
  bit          rx_quiet;
  bit          rx_hold_req;
  logic [31:0] key_pool [POOL_SIZE];

  lru_key_value_cache_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  lru_result_checker results (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stall bursts, or one long hold on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall   <= 1'b0;
        rx_hold_req = 1'b0;
      end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic m, input logic [31:0] k, input logic [31:0] v);
    in_valid <= 1'b1;
    in_word  <= '{mode: m, key: k, write_value: v};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic pause(input int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return KEY_ZERO;
      3:       return KEY_ONES;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int n,
                                  input int hold_at, input int pause_at, input bit quiet_tail);
    int          eff;
    int          span;
    logic        m;
    logic [31:0] k;
    eff  = (cap == 0) ? 1 : (int'(cap) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cap);
    span = (eff + 4 > POOL_SIZE) ? POOL_SIZE : eff + 4;
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = KEY_ZERO;
    key_pool[3] = KEY_ONES;
    for (int i = 4; i < POOL_SIZE; i++) begin
      key_pool[i] = $urandom;
    end
    set_capacity(cap);
    for (int j = 0; j < n; j++) begin
      if (quiet_tail && j >= n - 150) begin
        rx_quiet = 1'b1;
      end
      if (j == hold_at) begin
        rx_hold_req = 1'b1;
      end
      if (j == pause_at) begin
        drain();
      end
      if (!rx_quiet && $urandom_range(0, 4) == 0) begin
        pause($urandom_range(1, 11));
      end
      m = ($urandom_range(0, 1) == 0) ? MODE_LOOKUP : MODE_WRITE;
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, span - 1)];
      send_word(m, k, pick_value());
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_word     <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;
    rx_quiet    = 1'b0;
    rx_hold_req = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // capacity zero behaves as one
    set_capacity(5'd0);
    send_word(MODE_LOOKUP, KEY_ZERO, KEY_ONES);
    send_word(MODE_WRITE,  KEY_MIN,  KEY_MAX);
    send_word(MODE_LOOKUP, KEY_MIN,  KEY_ZERO);
    send_word(MODE_WRITE,  KEY_MAX,  KEY_MIN);
    send_word(MODE_LOOKUP, KEY_MIN,  KEY_ZERO);
    send_word(MODE_WRITE,  KEY_MAX,  KEY_ONES);
    send_word(MODE_LOOKUP, KEY_MAX,  KEY_ZERO);

    // recency order decides the victim
    set_capacity(5'd3);
    send_word(MODE_WRITE,  KEY_ZERO,     KEY_ZERO);
    send_word(MODE_WRITE,  KEY_ONES,     32'h1234_5678);
    send_word(MODE_LOOKUP, KEY_MAX,      KEY_ZERO);
    send_word(MODE_WRITE,  32'h0000_0001, 32'h0000_0001);
    send_word(MODE_LOOKUP, KEY_ONES,     KEY_ZERO);
    send_word(MODE_WRITE,  32'h0000_0002, 32'hdead_beef);
    send_word(MODE_LOOKUP, 32'h0000_0002, KEY_ONES);

    // capacity dropped below the current count
    set_capacity(5'd1);
    send_word(MODE_WRITE,  32'h0000_0003, 32'h5555_aaaa);
    send_word(MODE_WRITE,  32'h0000_0004, 32'haaaa_5555);
    send_word(MODE_LOOKUP, 32'h0000_0003, KEY_ZERO);
    send_word(MODE_WRITE,  32'h0000_0004, KEY_MIN);

    run_random_phase(5'd31, 200, 40, -1, 1'b0);
    run_random_phase(5'd16, 200, -1, -1, 1'b0);
    run_random_phase(5'd2,  200, -1, 100, 1'b0);
    run_random_phase(5'd17, 200, 60, -1, 1'b0);
    run_random_phase(5'd5,  200, -1, -1, 1'b0);
    run_random_phase(CAP_W'($urandom_range(1, 16)), 200, -1, -1, 1'b0);
    run_random_phase(5'd8,  200, -1, -1, 1'b1);

    drain();
    repeat (40) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
